FILE: hdl/radj_pkg.sv
// ---------------------------------------------------------------------------
// radj_pkg - shared types and constants for the radar Jacobian pipeline
// Stage map, per-item pipeline record and output packing helpers.
// ---------------------------------------------------------------------------
package radj_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int RANGE_W   = FRAC_BITS + 2;
   localparam int MIN_W     = 16;
   localparam logic [MIN_W-1:0] MIN_RADIUS_SQ_RST = 16'd7;

   // stream payload widths
   localparam int REQ_W = 4 * DATA_W;
   localparam int RSP_W = 4 * RANGE_W + 4 * DATA_W;

   // stage map (register index of the stage that does the work)
   localparam int K_IN   = 0;   // input capture
   localparam int K_ABS  = 1;   // magnitudes and signs
   localparam int K_MUL  = 2;   // squares and cross products
   localparam int K_SUM  = 3;   // r^2 and cross term
   localparam int K_MAG  = 4;   // degenerate test, |cross|, unit setup
   localparam int K_SQ0  = 5;   // 32 root steps
   localparam int SQ_N   = 32;
   localparam int K_BR0  = 5;   // 25 bearing quotient steps
   localparam int BR_N   = 25;
   localparam int K_XP   = 5;   // numerator partial products
   localparam int K_XS   = 6;   // numerator sum
   localparam int K_DP   = K_SQ0 + SQ_N;  // S*R partial products
   localparam int K_DS   = K_DP + 1;      // S*R sum
   localparam int K_RG0  = K_DS;          // 17 range quotient steps
   localparam int RG_N   = 17;
   localparam int K_RT0  = K_DS + 1;      // 33 rate quotient steps
   localparam int RT_N   = 33;
   localparam int K_OUT  = K_RT0 + RT_N;  // output register

   typedef struct packed {
      logic signed [31:0] p;
      logic signed [31:0] q;
      logic signed [31:0] u;
      logic signed [31:0] v;
      logic [31:0]        ap;
      logic [31:0]        aq;
      logic               sp;
      logic               sq;
      logic [63:0]        m_pp;
      logic [63:0]        m_qq;
      logic signed [63:0] m_uq;
      logic signed [63:0] m_vp;
      logic [63:0]        s;
      logic [64:0]        diff;
      logic               degen;
      logic [63:0]        dmag;
      logic               dneg;
      logic [33:0]        sr_rem;
      logic [31:0]        sr_root;
      logic [63:0]        bp_rem;
      logic [63:0]        bq_rem;
      logic [24:0]        bp_quo;
      logic [24:0]        bq_quo;
      logic [63:0]        xp_lo;
      logic [63:0]        xp_hi;
      logic [63:0]        xq_lo;
      logic [63:0]        xq_hi;
      logic [95:0]        xp;
      logic [95:0]        xq;
      logic [63:0]        dd_lo;
      logic [63:0]        dd_hi;
      logic [95:0]        dd;
      logic [31:0]        rp_rem;
      logic [31:0]        rq_rem;
      logic [16:0]        rp_quo;
      logic [16:0]        rq_quo;
      logic [95:0]        tp_rem;
      logic [95:0]        tq_rem;
      logic [32:0]        tp_quo;
      logic [32:0]        tq_quo;
      logic               tp_ovf;
      logic               tq_ovf;
      logic [RSP_W-1:0]   o_data;
      logic               o_degen;
   } item_type;

   // signed range entry from a magnitude of at most 2^16
   function automatic logic [RANGE_W-1:0] pack_range(input logic [16:0] mag,
                                                     input logic neg);
      logic [RANGE_W-1:0] v;
      v = {1'b0, mag};
      return neg ? RANGE_W'(-v) : v;
   endfunction

   // bearing entry, magnitude below 2^25 so no clamp is reached
   function automatic logic [DATA_W-1:0] pack_bearing(input logic [24:0] mag,
                                                      input logic neg);
      logic [DATA_W-1:0] v;
      v = {7'd0, mag};
      return neg ? DATA_W'(-v) : v;
   endfunction

   // rate entry, clamped to the 32-bit signed range
   function automatic logic [DATA_W-1:0] pack_rate(input logic [32:0] mag,
                                                   input logic ovf,
                                                   input logic neg);
      logic [32:0] lim;
      logic [32:0] v;
      lim = neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      v   = (ovf || mag > lim) ? lim : mag;
      return neg ? DATA_W'(-v) : v[DATA_W-1:0];
   endfunction

endpackage

FILE: hdl/radar_jacobian.sv
// ---------------------------------------------------------------------------
// radar_jacobian - radar measurement Jacobian, fully pipelined
// Range, bearing and range-rate partials of one Q16.16 state vector.
// ---------------------------------------------------------------------------
// Takes one state vector (px, py, vx, vy, signed Q16.16) per transfer and
// returns the eight nonzero entries of the 3x4 radar Jacobian plus a
// degenerate flag. A new transfer is accepted every clock cycle unless the
// pipe holds; its depth is set by the bit-serial units laid out along the
// pipe: a 32-step square root for r followed by a 33-step quotient for the
// 1/r^3 terms. Results leave in request order. When rsp_tready is low
// with a result waiting, the whole pipe holds and req_tready drops; bubbles
// travel as cleared valid bits. If the Q16.16 value of r^2 is at or below
// csr_wdata last written (reset value 7), every entry is zero and the flag in
// rsp_tuser is set. Write csr only while no transfer is in flight.
// ---------------------------------------------------------------------------
module radar_jacobian
   import radj_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // request: pos_x [31:0], pos_y [63:32], vel_x [95:64], vel_y [127:96]
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   // response: range_by_px [17:0], range_by_py [35:18], bearing_by_px [67:36],
   //   bearing_by_py [99:68], rate_by_px [131:100], rate_by_py [163:132],
   //   rate_by_vx [181:164], rate_by_vy [199:182]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   // response flag: degenerate [0]
   output logic             rsp_tuser,
   // min_radius_sq register
   input  logic             csr_wen,
   input  logic [MIN_W-1:0] csr_wdata
);

   logic [MIN_W-1:0] min_radius_sq_ff;
   logic [K_OUT:0]   vld_ff;
   item_type         pipe_ff [K_OUT+1];
   item_type         pipe_in [K_OUT+1];
   logic             adv;

   // ---- one stage of work; k is fixed per stage so the unused arms fold away
   function automatic item_type step(input item_type a, input int k,
                                     input logic [MIN_W-1:0] min_r);
      item_type    n;
      logic [35:0] st;
      logic [35:0] tr;
      logic [64:0] bt;
      logic [32:0] rt;
      logic [96:0] tt;
      logic        bit_in;
      int          j;
      int          idx;
      n = a;
      if (k == K_ABS) begin
         n.ap = a.p[31] ? 32'(-a.p) : 32'(a.p);
         n.aq = a.q[31] ? 32'(-a.q) : 32'(a.q);
         n.sp = a.p[31];
         n.sq = a.q[31];
      end
      if (k == K_MUL) begin
         n.m_pp = a.ap * a.ap;
         n.m_qq = a.aq * a.aq;
         n.m_uq = a.u * a.q;
         n.m_vp = a.v * a.p;
      end
      if (k == K_SUM) begin
         n.s    = a.m_pp + a.m_qq;
         n.diff = {a.m_uq[63], a.m_uq} - {a.m_vp[63], a.m_vp};
      end
      if (k == K_MAG) begin
         n.degen   = a.s[63:16] <= {32'd0, min_r};
         n.dneg    = a.diff[64];
         n.dmag    = a.diff[64] ? 64'(-a.diff) : a.diff[63:0];
         n.sr_rem  = '0;
         n.sr_root = '0;
         // quotient of a*2^32/S stays below 2^25: start at a*2^32 >> 25
         n.bp_rem  = {25'd0, a.ap, 7'd0};
         n.bq_rem  = {25'd0, a.aq, 7'd0};
         n.bp_quo  = '0;
         n.bq_quo  = '0;
      end
      // square root, two radicand bits per stage
      if (k >= K_SQ0 && k < K_SQ0 + SQ_N) begin
         j  = k - K_SQ0;
         st = {a.sr_rem, a.s[63-2*j -: 2]};
         tr = {2'b00, a.sr_root, 2'b01};
         if (st >= tr) begin
            n.sr_rem  = 34'(st - tr);
            n.sr_root = {a.sr_root[30:0], 1'b1};
         end else begin
            n.sr_rem  = st[33:0];
            n.sr_root = {a.sr_root[30:0], 1'b0};
         end
      end
      // bearing quotients by S, numerator low bits are zero
      if (k >= K_BR0 && k < K_BR0 + BR_N) begin
         bt = {a.bp_rem, 1'b0};
         if (bt >= {1'b0, a.s}) begin
            n.bp_rem = 64'(bt - {1'b0, a.s});
            n.bp_quo = {a.bp_quo[23:0], 1'b1};
         end else begin
            n.bp_rem = bt[63:0];
            n.bp_quo = {a.bp_quo[23:0], 1'b0};
         end
         bt = {a.bq_rem, 1'b0};
         if (bt >= {1'b0, a.s}) begin
            n.bq_rem = 64'(bt - {1'b0, a.s});
            n.bq_quo = {a.bq_quo[23:0], 1'b1};
         end else begin
            n.bq_rem = bt[63:0];
            n.bq_quo = {a.bq_quo[23:0], 1'b0};
         end
      end
      // position times |cross term|
      if (k == K_XP) begin
         n.xp_lo = a.ap * a.dmag[31:0];
         n.xp_hi = a.ap * a.dmag[63:32];
         n.xq_lo = a.aq * a.dmag[31:0];
         n.xq_hi = a.aq * a.dmag[63:32];
      end
      if (k == K_XS) begin
         n.xp = {a.xp_hi, 32'd0} + {32'd0, a.xp_lo};
         n.xq = {a.xq_hi, 32'd0} + {32'd0, a.xq_lo};
      end
      // S*R for the 1/r^3 divisor; unit setup for range and rate
      if (k == K_DP) begin
         n.dd_lo  = a.s[31:0] * a.sr_root;
         n.dd_hi  = a.s[63:32] * a.sr_root;
         n.rp_rem = {1'b0, a.ap[31:1]};
         n.rq_rem = {1'b0, a.aq[31:1]};
         n.rp_quo = '0;
         n.rq_quo = '0;
         n.tp_rem = {17'd0, a.xp[95:17]};
         n.tq_rem = {17'd0, a.xq[95:17]};
         n.tp_quo = '0;
         n.tq_quo = '0;
      end
      if (k == K_DS) begin
         n.dd = {a.dd_hi, 32'd0} + {32'd0, a.dd_lo};
      end
      // range quotients a*2^16 / R
      if (k >= K_RG0 && k < K_RG0 + RG_N) begin
         j = k - K_RG0;
         bit_in = (j == 0) ? a.ap[0] : 1'b0;
         rt = {a.rp_rem, bit_in};
         if (rt >= {1'b0, a.sr_root}) begin
            n.rp_rem = 32'(rt - {1'b0, a.sr_root});
            n.rp_quo = {a.rp_quo[15:0], 1'b1};
         end else begin
            n.rp_rem = rt[31:0];
            n.rp_quo = {a.rp_quo[15:0], 1'b0};
         end
         bit_in = (j == 0) ? a.aq[0] : 1'b0;
         rt = {a.rq_rem, bit_in};
         if (rt >= {1'b0, a.sr_root}) begin
            n.rq_rem = 32'(rt - {1'b0, a.sr_root});
            n.rq_quo = {a.rq_quo[15:0], 1'b1};
         end else begin
            n.rq_rem = rt[31:0];
            n.rq_quo = {a.rq_quo[15:0], 1'b0};
         end
      end
      // rate quotients x*2^16 / (S*R); overflow past 33 bits clamps later
      if (k >= K_RT0 && k < K_RT0 + RT_N) begin
         j   = k - K_RT0;
         idx = RT_N - 1 - j;
         if (j == 0) begin
            n.tp_ovf = a.tp_rem >= a.dd;
            n.tq_ovf = a.tq_rem >= a.dd;
         end
         bit_in = (idx >= FRAC_BITS) ? a.xp[idx-FRAC_BITS] : 1'b0;
         tt = {a.tp_rem, bit_in};
         if (tt >= {1'b0, a.dd}) begin
            n.tp_rem = 96'(tt - {1'b0, a.dd});
            n.tp_quo = {a.tp_quo[31:0], 1'b1};
         end else begin
            n.tp_rem = tt[95:0];
            n.tp_quo = {a.tp_quo[31:0], 1'b0};
         end
         bit_in = (idx >= FRAC_BITS) ? a.xq[idx-FRAC_BITS] : 1'b0;
         tt = {a.tq_rem, bit_in};
         if (tt >= {1'b0, a.dd}) begin
            n.tq_rem = 96'(tt - {1'b0, a.dd});
            n.tq_quo = {a.tq_quo[31:0], 1'b1};
         end else begin
            n.tq_rem = tt[95:0];
            n.tq_quo = {a.tq_quo[31:0], 1'b0};
         end
      end
      // sign, clamp and pack
      if (k == K_OUT) begin
         n.o_degen = a.degen;
         if (a.degen) begin
            n.o_data = '0;
         end else begin
            n.o_data = {
               pack_range(a.rq_quo, a.sq),
               pack_range(a.rp_quo, a.sp),
               pack_rate(a.tp_quo, a.tp_ovf, a.sp ^ (!a.dneg && a.dmag != '0)),
               pack_rate(a.tq_quo, a.tq_ovf, a.sq ^ a.dneg),
               pack_bearing(a.bp_quo, a.sp),
               pack_bearing(a.bq_quo, !a.sq),
               pack_range(a.rq_quo, a.sq),
               pack_range(a.rp_quo, a.sp)};
         end
      end
      return n;
   endfunction

   // whole pipe moves together; it only holds when a finished result waits
   assign adv        = !vld_ff[K_OUT] || rsp_tready;
   assign req_tready = adv;

   always_comb begin
      pipe_in[K_IN]   = '0;
      pipe_in[K_IN].p = req_tdata[DATA_W-1:0];
      pipe_in[K_IN].q = req_tdata[2*DATA_W-1:DATA_W];
      pipe_in[K_IN].u = req_tdata[3*DATA_W-1:2*DATA_W];
      pipe_in[K_IN].v = req_tdata[4*DATA_W-1:3*DATA_W];
   end

   for (genvar k = 1; k <= K_OUT; k++) begin : g_stage
      assign pipe_in[k] = step(pipe_ff[k-1], k, min_radius_sq_ff);
   end

   for (genvar k = 0; k <= K_OUT; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (adv) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[K_OUT-1:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_radius_sq_ff <= MIN_RADIUS_SQ_RST;
      end else if (csr_wen) begin
         min_radius_sq_ff <= csr_wdata;
      end
   end

   assign rsp_tvalid = vld_ff[K_OUT];
   assign rsp_tdata  = pipe_ff[K_OUT].o_data;
   assign rsp_tuser  = pipe_ff[K_OUT].o_degen;

endmodule
